FILE: rtl/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg
// types and constants shared by the pivot scaled point mapper
// ----------------------------------------------------------------------------
`default_nettype none

package psm_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned ScaleWidth = 24;
  localparam int unsigned PivotWidth = 17;
  localparam int unsigned SizeWidth  = 16;
  localparam int unsigned IndexWidth = 3;
  localparam int unsigned DataWidth  = 24;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef enum logic [IndexWidth-1:0] {
    REG_POS_X   = 3'd0,
    REG_POS_Y   = 3'd1,
    REG_WIDTH   = 3'd2,
    REG_HEIGHT  = 3'd3,
    REG_SCALE_X = 3'd4,
    REG_SCALE_Y = 3'd5,
    REG_PIVOT_X = 3'd6,
    REG_PIVOT_Y = 3'd7
  } reg_index_t;

  localparam logic OP_TO_SCREEN = 1'b0;
  localparam logic OP_TO_LOCAL  = 1'b1;

  // flags that follow a word down the pipeline
  typedef struct packed {
    logic op;
    logic zero;
  } psm_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/psm_origin.sv
// ----------------------------------------------------------------------------
// psm_origin
// scaled top-left of one axis from the configuration registers
// ----------------------------------------------------------------------------
`default_nettype none

module psm_origin #(
  parameter int unsigned FRAC = 16
) (
  input  wire logic                                   clk,
  input  wire logic signed [psm_pkg::CoordWidth-1:0]  pos,
  input  wire logic        [psm_pkg::SizeWidth-1:0]   size,
  input  wire logic signed [psm_pkg::ScaleWidth-1:0]  scale,
  input  wire logic        [psm_pkg::PivotWidth-1:0]  pivot,
  output logic signed [39:0]                          origin
);
  import psm_pkg::*;

  localparam int unsigned Shift = 16 + FRAC;

  logic        [32:0] sp;
  logic signed [25:0] oms;
  logic signed [60:0] prod;
  logic signed [72:0] num;
  logic        [72:0] mag;
  logic        [72:0] rnd;

  // settled from registers that the user must keep quiet while words move (the block
  // itself does not enforce this), so one path per cycle of use is free to be multi-cycle
  always_ff @(posedge clk) begin
    sp   <= 33'(size) * 33'(pivot);
    oms  <= (26'sd1 <<< FRAC) - 26'(scale);
    prod <= $signed({1'b0, sp}) * 61'(oms);
    num  <= 73'(prod) + (73'(pos) <<< Shift);
    mag  <= num[72] ? 73'(-num) : num;
    rnd  <= (mag + (73'd1 << (Shift - 1))) >> Shift;
    origin <= num[72] ? -40'(rnd) : 40'(rnd);
  end

endmodule

`default_nettype wire

FILE: rtl/psm_div.sv
// ----------------------------------------------------------------------------
// psm_div
// pipelined restoring divider, one quotient bit per stage, truncating
// ----------------------------------------------------------------------------
`default_nettype none

module psm_div #(
  parameter int unsigned NW = 58,
  parameter int unsigned DW = 24
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] quo
);
  import psm_pkg::*;

  logic [NW-1:0] q   [NW+1];
  logic [DW:0]   r   [NW+1];
  logic [DW-1:0] d   [NW+1];

  always_comb begin
    q[0] = num;
    r[0] = '0;
    d[0] = den;
  end

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW:0] t;
    logic [DW:0] s;
    assign t = {r[i][DW-1:0], q[i][NW-1]};
    assign s = t - {1'b0, d[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        r[i+1] <= s[DW] ? t : s;
        q[i+1] <= {q[i][NW-2:0], ~s[DW]};
        d[i+1] <= d[i];
      end
    end
  end

  assign quo = q[NW];

endmodule

`default_nettype wire

FILE: rtl/pivot_scaled_point_mapper_top.sv
// ----------------------------------------------------------------------------
// pivot_scaled_point_mapper_top
// maps points between window local and screen coordinates about a pivot
// ----------------------------------------------------------------------------
// channel  direction  handshake
// in       input      in_valid / in_stall   opcode, coord_x, coord_y
// out      output     out_valid / out_stall out_x, out_y, scale_zero, saturated
// cfg      input      cfg_we                cfg_index, cfg_data
//
// one word per cycle unless the pipe is frozen; most of the pipe is the bit-per-stage
// divider. the whole pipe freezes while out_stall is high and a word waits.
// reset clears the registers to their defaults and empties the pipe.
// after a configuration write let the origin registers settle before the next word.
`default_nettype none

module pivot_scaled_point_mapper_top #(
  parameter int unsigned SCALE_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic signed [15:0] coord_x,
  input  wire logic signed [15:0] coord_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic             scale_zero,
  output logic             saturated,
  input  wire logic        cfg_we,
  input  wire logic [psm_pkg::IndexWidth-1:0] cfg_index,
  input  wire logic [psm_pkg::DataWidth-1:0]  cfg_data
);
  import psm_pkg::*;

  localparam int unsigned F  = SCALE_FRAC_BITS;
  localparam int unsigned NW = 42 + F;
  localparam int unsigned DL = NW + 2;
  localparam logic [23:0] ZLim = 24'(((64'd1 << F) + 64'd999999) / 64'd1000000);

  logic signed [15:0] pos [2];
  logic        [15:0] size [2];
  logic signed [23:0] scale [2];
  logic        [16:0] pivot [2];
  logic signed [39:0] org [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 2; a++) begin
        pos[a] <= '0; size[a] <= '0; pivot[a] <= '0;
        scale[a] <= 24'sd65536;
      end
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_POS_X:   pos[0]   <= cfg_data[15:0];
        REG_POS_Y:   pos[1]   <= cfg_data[15:0];
        REG_WIDTH:   size[0]  <= cfg_data[15:0];
        REG_HEIGHT:  size[1]  <= cfg_data[15:0];
        REG_SCALE_X: scale[0] <= cfg_data;
        REG_SCALE_Y: scale[1] <= cfg_data;
        REG_PIVOT_X: pivot[0] <= cfg_data[16:0];
        REG_PIVOT_Y: pivot[1] <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_org
    psm_origin #(.FRAC(F)) u_org (
      .clk(clk), .pos(pos[a]), .size(size[a]), .scale(scale[a]),
      .pivot(pivot[a]), .origin(org[a]));
  end

  logic en;
  logic [DL:0] vld;
  assign en = !(vld[DL] && out_stall);
  assign in_stall = !en;

  logic zflag;
  always_comb begin
    zflag = 1'b0;
    for (int a = 0; a < 2; a++) begin
      if ((scale[a][23] ? 24'(-scale[a]) : scale[a]) < ZLim) zflag = 1'b1;
    end
  end

  // stage 1: capture, product and difference
  psm_ctl_t c1;
  logic signed [39:0] prd1 [2];
  logic signed [41:0] dif1 [2];
  logic signed [40:0] org1 [2];
  logic               neg1 [2];
  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= '{op: opcode, zero: opcode && zflag};
      for (int a = 0; a < 2; a++) begin
        prd1[a] <= 40'(a == 0 ? coord_x : coord_y) * 40'(scale[a]);
        dif1[a] <= 42'(a == 0 ? coord_x : coord_y) - 42'(org[a]);
        org1[a] <= 41'(org[a]);
        neg1[a] <= scale[a][23];
      end
    end
  end

  // stage 2: rounding for screen, magnitudes for divider
  psm_ctl_t c2;
  logic signed [41:0] scr2 [2];
  logic [NW-1:0] n2 [2];
  logic [23:0]   d2 [2];
  logic          sg2 [2];
  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c1;
      for (int a = 0; a < 2; a++) begin
        logic [39:0] m;
        logic [39:0] r;
        m = prd1[a][39] ? 40'(-prd1[a]) : 40'(prd1[a]);
        r = (m + (40'd1 << (F - 1))) >> F;
        scr2[a] <= 42'(org1[a]) + (prd1[a][39] ? -42'(r) : 42'(r));
        n2[a] <= NW'(dif1[a][41] ? 42'(-dif1[a]) : 42'(dif1[a])) << F;
        d2[a] <= neg1[a] ? 24'(-scale[a]) : 24'(scale[a]);
        sg2[a] <= dif1[a][41] ^ neg1[a];
      end
    end
  end

  logic [NW-1:0] quo [2];
  for (genvar a = 0; a < 2; a++) begin : g_div
    psm_div #(.NW(NW), .DW(24)) u_div (
      .clk(clk), .en(en), .num(n2[a]), .den(d2[a] == '0 ? 24'd1 : d2[a]),
      .quo(quo[a]));
  end

  // delay line beside the divider
  psm_ctl_t          cd  [NW+1];
  logic signed [41:0] sd [NW+1][2];
  logic               gd [NW+1][2];
  always_comb begin
    cd[0] = c2;
    sd[0] = scr2;
    gd[0] = sg2;
  end
  for (genvar i = 0; i < NW; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        cd[i+1] <= cd[i];
        sd[i+1] <= sd[i];
        gd[i+1] <= gd[i];
      end
    end
  end

  // last stage: select, zero on scale_zero, saturate
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [NW:0] v [2];
      logic s;
      s = 1'b0;
      for (int a = 0; a < 2; a++) begin
        if (cd[NW].op == OP_TO_SCREEN) v[a] = (NW+1)'(sd[NW][a]);
        else v[a] = gd[NW][a] ? -(NW+1)'(quo[a]) : (NW+1)'(quo[a]);
        if (cd[NW].zero) v[a] = '0;
        if (v[a] > 32767) begin v[a] = 32767; s = 1'b1; end
        else if (v[a] < -32768) begin v[a] = -32768; s = 1'b1; end
      end
      out_x <= 16'(v[0]);
      out_y <= 16'(v[1]);
      scale_zero <= cd[NW].zero;
      saturated <= s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DL-1:0], in_valid};
  end
  assign out_valid = vld[DL];

`ifndef NO_ASSERTIONS
  a_zero_nosat: assert property (@(posedge clk) disable iff (rst)
    out_valid && scale_zero |-> !saturated && out_x == 0 && out_y == 0)
    else $error("zero scale word carries data");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("stalled word changed");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

FILE: verif/pivot_scaled_point_mapper_top_tb.sv
// ----------------------------------------------------------------------------
// pivot_scaled_point_mapper_top_tb
// checks point mapping against an independent predictor across several
// window, scale and pivot settings, with random idling on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pivot_scaled_point_mapper_top_tb;
  import psm_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 44;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               zero;
    logic               sat;
  } mapped_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic opcode;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic scale_zero;
  logic saturated;
  logic cfg_we;
  logic [IndexWidth-1:0] cfg_index;
  logic [DataWidth-1:0] cfg_data;

  longint win_pos[2];
  longint win_size[2];
  longint win_scale[2];
  longint win_pivot[2];

  mapped_t expected_points[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int hold_cycles = 0;
  bit quiet_rx = 0;

  pivot_scaled_point_mapper_top #(.SCALE_FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .coord_x(coord_x), .coord_y(coord_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .scale_zero(scale_zero), .saturated(saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("pivot_scaled_point_mapper_top: mismatch");
    $finish;
  end

  function automatic longint round_half_away(longint v, int k);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (k - 1))) >>> k;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clamp16(longint v, ref bit sat);
    if (v > 32767) begin
      sat = 1;
      return 32767;
    end
    if (v < -32768) begin
      sat = 1;
      return -32768;
    end
    return v;
  endfunction

  function automatic longint scaled_corner(int a);
    longint num;
    num = win_size[a] * win_pivot[a] * ((64'sd1 <<< FRAC) - win_scale[a]);
    num += win_pos[a] * (64'sd1 <<< (16 + FRAC));
    return round_half_away(num, 16 + FRAC);
  endfunction

  function automatic bit scale_is_zero(longint s);
    longint m;
    m = (s < 0) ? -s : s;
    return m * 1000000 < (64'sd1 <<< FRAC);
  endfunction

  function automatic mapped_t map_point(logic op, logic signed [15:0] cx,
                                        logic signed [15:0] cy);
    mapped_t r;
    longint c[2];
    longint v[2];
    longint d;
    bit sat;
    sat = 0;
    c[0] = cx;
    c[1] = cy;
    r = '0;
    if (op == OP_TO_SCREEN) begin
      for (int a = 0; a < 2; a++) begin
        d = scaled_corner(a) + round_half_away(c[a] * win_scale[a], FRAC);
        v[a] = clamp16(d, sat);
      end
    end else if (scale_is_zero(win_scale[0]) || scale_is_zero(win_scale[1])) begin
      r.zero = 1;
      v[0] = 0;
      v[1] = 0;
    end else begin
      for (int a = 0; a < 2; a++) begin
        d = c[a] - scaled_corner(a);
        v[a] = clamp16((d * (64'sd1 <<< FRAC)) / win_scale[a], sat);
      end
    end
    r.x = v[0][15:0];
    r.y = v[1][15:0];
    r.sat = sat;
    return r;
  endfunction

  // register write, only while the pipe is empty
  task automatic write_reg(reg_index_t idx, longint value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value[DataWidth-1:0];
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_POS_X: win_pos[0] = $signed(value[15:0]);
      REG_POS_Y: win_pos[1] = $signed(value[15:0]);
      REG_WIDTH: win_size[0] = value[15:0];
      REG_HEIGHT: win_size[1] = value[15:0];
      REG_SCALE_X: win_scale[0] = $signed(value[23:0]);
      REG_SCALE_Y: win_scale[1] = $signed(value[23:0]);
      REG_PIVOT_X: win_pivot[0] = value[16:0];
      REG_PIVOT_Y: win_pivot[1] = value[16:0];
      default: ;
    endcase
    repeat (8) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic setup(longint px, longint py, longint w, longint h,
                       longint sx, longint sy, longint vx, longint vy);
    drain();
    write_reg(REG_POS_X, px);
    write_reg(REG_POS_Y, py);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_PIVOT_X, vx);
    write_reg(REG_PIVOT_Y, vy);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid stays high after the word unless a gap or a pause follows
  task automatic send_point(logic op, logic signed [15:0] cx, logic signed [15:0] cy,
                            bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    coord_x <= cx;
    coord_y <= cy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_points.push_back(map_point(op, cx, cy));
    sent++;
  endtask

  function automatic logic signed [15:0] rand_coord();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'sh7fff;
    if (p == 1) return 16'sh8000;
    if (p < 5) return $signed(16'($urandom_range(0, 400)) - 16'sd200);
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    logic signed [15:0] edges[4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
    setup(100, -50, 640, 480, 32768, 131072, 32768, 65536);
    foreach (edges[i]) begin
      send_point(OP_TO_SCREEN, edges[i], edges[3 - i], 0);
      send_point(OP_TO_LOCAL, edges[i], edges[i], 0);
    end
    // exact zero scale on one axis, then near-zero scales on both axes
    setup(16'h7fff, 16'h8000, 16'hffff, 16'hffff, 0, 65536, 65536, 16'hffff);
    send_point(OP_TO_LOCAL, 5, 5, 0);
    send_point(OP_TO_SCREEN, 5, -5, 0);
    setup(0, 0, 100, 100, 1, -1, 131071, 65537);
    send_point(OP_TO_LOCAL, 1, 1, 0);
    send_point(OP_TO_SCREEN, 32767, -32768, 0);
    // extreme scales, pivot above one
    setup(-32768, 32767, 65535, 1, 24'h7fffff, 24'h800000, 131071, 0);
    send_point(OP_TO_SCREEN, 1, -1, 0);
    send_point(OP_TO_LOCAL, 32767, -32768, 0);
    send_point(OP_TO_SCREEN, 0, 0, 0);
    send_point(OP_TO_LOCAL, -3, 3, 0);
  endtask

  task automatic test_random_phase(int count);
    longint sx;
    longint sy;
    sx = $urandom_range(0, 3) == 0 ? $signed(24'($urandom)) :
         $signed(24'($urandom_range(0, 262144))) - 131072;
    sy = $urandom_range(0, 3) == 0 ? $signed(24'($urandom)) :
         $signed(24'($urandom_range(0, 262144))) - 131072;
    setup($urandom, $urandom, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000),
          $urandom, sx, sy, $urandom_range(0, 131071), $urandom_range(0, 65536));
    repeat (count) send_point(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), 1);
  endtask

  task automatic test_back_pressure();
    hold_cycles = 150;
    repeat (80) send_point(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), 0);
    in_valid <= 0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (20) send_point(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), 1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else if (quiet_rx) begin
      out_stall <= 0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30) ||
                   (out_stall && $urandom_range(0, 99) < 60);
    end
  end

  always @(posedge clk) begin
    mapped_t exp_pt;
    if (!rst && out_valid && !out_stall) begin
      received++;
      if (expected_points.size() == 0) begin
        $error("unexpected word x=%0d y=%0d", out_x, out_y);
        errors++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (out_x !== exp_pt.x) begin
          $error("out_x expected %0d actual %0d", exp_pt.x, out_x);
          errors++;
        end
        if (out_y !== exp_pt.y) begin
          $error("out_y expected %0d actual %0d", exp_pt.y, out_y);
          errors++;
        end
        if (scale_zero !== exp_pt.zero) begin
          $error("scale_zero expected %0b actual %0b", exp_pt.zero, scale_zero);
          errors++;
        end
        if (saturated !== exp_pt.sat) begin
          $error("saturated expected %0b actual %0b", exp_pt.sat, saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1;
    in_valid = 0;
    opcode = 0;
    coord_x = 0;
    coord_y = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    for (int a = 0; a < 2; a++) begin
      win_pos[a] = 0;
      win_size[a] = 0;
      win_scale[a] = 65536;
      win_pivot[a] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // defaults after reset
    send_point(OP_TO_SCREEN, 7, -7, 0);
    send_point(OP_TO_LOCAL, -32768, 32767, 0);
    test_directed();
    repeat (6) test_random_phase(100);
    test_back_pressure();
    quiet_rx = 1;
    test_random_phase(40);
    quiet_rx = 0;
    drain();
    $display("covered %0d words over reset, directed and random settings", sent);
    $display("including zero scales, saturation and a long receiver hold-off");
    if (errors == 0) begin
      $display("pivot_scaled_point_mapper_top: match");
    end else begin
      $display("pivot_scaled_point_mapper_top: mismatch");
    end
    $finish;
  end

endmodule
